@@ rtl/sfla_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types and constants of the slab free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int CNT_W          = 9;     // object_count / free count width
    localparam int SIZE_W         = 23;    // object_size width
    localparam int BUS_W          = 32;    // configuration data width
    localparam int FIELD_ADDR_W   = 32;    // address fields on the stream ports
    localparam int PADDR_W        = 4;     // four registers at 4-byte spacing
    localparam int OUT_W          = 48;    // packed result request, byte padded

    localparam int NUM_OBJS_DEF   = 256;
    localparam int ADDR_WIDTH_DEF = 32;
    localparam int CNT_RESET      = 256;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = 23'd4;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 23'd4194304;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 23'd16;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_NO_FREE  = 3'd1;
    localparam t_status ST_DOUBLE   = 3'd2;
    localparam t_status ST_OUTSIDE  = 3'd3;
    localparam t_status ST_ALL_FREE = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        REG_COUNT,
        REG_SIZE,
        REG_BASE,
        REG_CHECK
    } t_reg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_ALLOC_WB,
        S_SPAN,
        S_RANGE,
        S_DIV,
        S_WALK_CHK,
        S_WALK_LD,
        S_PUSH,
        S_DONE
    } t_state;

endpackage

@@ rtl/slab_free_list_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_free_list_allocator
// Allocates and frees equal-sized objects of one slab via a linked free list.
// ----------------------------------------------------------------------------
//   Requests enter on s_axis: tuser[0] is the operation (0 allocate, 1 free),
//   tdata the address to free. Each request yields exactly one result on
//   m_axis (status, address, free count, full/empty flags).
//   Registers (object_count, object_size, slab_base, check_enable) sit on
//   the APB port at byte offsets 0, 4, 8, 12; the user is to write them only
//   while idle, which the block itself does not enforce. One request at a time:
//   s_axis_tready is high only in the idle state. Allocate reads the head
//   link beside the address multiply; with no free object it goes straight
//   to the result. Free runs a span multiply and range compare (an address
//   outside the slab ends there), 9 shift-subtract divider steps and a push;
//   with checking on, a walk of the free list (one registered link read per
//   hop) comes before the push. Reset, and every object_count write, rebuilds
//   the link memory in a clearing pass during which no request is taken.
//   While m_axis_tready holds a result back, the next request is still taken
//   and run; its result then waits in the last state until the register frees.
// ----------------------------------------------------------------------------
module slab_free_list_allocator #(
    parameter int NUM_OBJS   = sfla_pkg::NUM_OBJS_DEF,
    parameter int ADDR_WIDTH = sfla_pkg::ADDR_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sfla_pkg::PADDR_W-1:0]      paddr,
    input  logic [sfla_pkg::BUS_W-1:0]        pwdata,
    output logic [sfla_pkg::BUS_W-1:0]        prdata,
    output logic                              pready,
    // requests
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sfla_pkg::FIELD_ADDR_W-1:0] s_axis_tdata,  // [31:0] object_address
    input  logic [0:0]                        s_axis_tuser,  // [0] operation
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [2:0] status, [34:3] result_address, [43:35] free_objects,
    // [44] slab_full, [45] slab_empty, [47:46] zero
    output logic [sfla_pkg::OUT_W-1:0]        m_axis_tdata
);

    localparam int CNT_W  = sfla_pkg::CNT_W;
    localparam int SIZE_W = sfla_pkg::SIZE_W;
    localparam int IW     = (NUM_OBJS > 1) ? $clog2(NUM_OBJS) : 1;
    localparam int LW     = $clog2(NUM_OBJS + 1);
    localparam int OW     = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int MW     = (LW > CNT_W) ? LW : CNT_W;
    localparam int PW     = MW + SIZE_W;
    localparam int KW     = (ADDR_WIDTH > PW) ? ADDR_WIDTH : PW;
    localparam int DIV_W  = CNT_W - 1 + SIZE_W;
    localparam int STEP_W = $clog2(CNT_W);
    localparam int CNT_RST_I = (sfla_pkg::CNT_RESET > NUM_OBJS) ? NUM_OBJS
                                                                 : sfla_pkg::CNT_RESET;
    localparam logic [CNT_W-1:0] COUNT_RST = CNT_W'(CNT_RST_I);
    localparam logic [IW-1:0]    LAST_IDX  = IW'(NUM_OBJS - 1);
    localparam logic [LW-1:0]    OBJ_LIM   = LW'(NUM_OBJS);

    // result field positions
    localparam int F_ADDR  = 3;
    localparam int F_FREE  = F_ADDR + sfla_pkg::FIELD_ADDR_W;
    localparam int F_FULL  = F_FREE + CNT_W;
    localparam int F_EMPTY = F_FULL + 1;
    localparam int F_PAD   = sfla_pkg::OUT_W - F_EMPTY - 1;

    // control registers
    sfla_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [OW-1:0]     r_base, n_base;
    logic              r_check, n_check;
    logic [LW-1:0]     r_head, n_head;
    logic [CNT_W-1:0]  r_free_count, n_free_count;
    logic [IW-1:0]     r_clr_idx, n_clr_idx;
    logic              r_m_valid, n_m_valid;

    // datapath registers
    logic [KW-1:0]              r_off, n_off;
    logic [PW-1:0]              r_prod, n_prod;
    logic [DIV_W-1:0]           r_rem, n_rem;
    logic [DIV_W-1:0]           r_dsr, n_dsr;
    logic [CNT_W-1:0]           r_q, n_q;
    logic [STEP_W-1:0]          r_step, n_step;
    logic [LW-1:0]              r_cur, n_cur;
    logic                       r_cur_ok, n_cur_ok;
    logic [CNT_W-1:0]           r_left, n_left;
    sfla_pkg::t_status          r_status, n_status;
    logic [OW-1:0]              r_result, n_result;
    logic [sfla_pkg::OUT_W-1:0] r_m_data, n_m_data;
    logic [LW-1:0]              r_mem_q;

    // link memory
    logic [LW-1:0] mem [NUM_OBJS];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;

    logic                  cfg_wr;
    sfla_pkg::t_reg        cfg_reg;
    logic [CNT_W-1:0]      wr_cnt_raw;
    logic [CNT_W-1:0]      wr_cnt;
    logic [SIZE_W-1:0]     wr_size_raw;
    logic [SIZE_W-1:0]     wr_size;
    logic                  in_acc;
    logic                  out_free;
    logic [MW-1:0]         mul_a;
    logic [PW-1:0]         mul_p;
    logic [ADDR_WIDTH-1:0] off_aw;
    logic                  div_ge;
    logic                  head_ok;

    assign pready        = 1'b1;
    assign cfg_wr        = psel & penable & pwrite;
    assign cfg_reg       = sfla_pkg::t_reg'(paddr[3:2]);
    assign s_axis_tready = (r_state == sfla_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // shared multiplier: index * size on allocate, count * size for the span
    assign mul_a = (r_state == sfla_pkg::S_ALLOC) ? MW'(r_head) : MW'(r_count);
    assign mul_p = PW'(mul_a) * PW'(r_size);

    assign off_aw  = ADDR_WIDTH'(s_axis_tdata) - ADDR_WIDTH'(r_base);
    assign div_ge  = (r_rem >= r_dsr);
    assign head_ok = (r_head < OBJ_LIM);

    assign wr_cnt_raw  = pwdata[CNT_W-1:0];
    assign wr_size_raw = pwdata[SIZE_W-1:0];

    always_comb begin
        priority if (wr_cnt_raw == '0) begin
            wr_cnt = CNT_W'(1);
        end else if (32'(wr_cnt_raw) > 32'(NUM_OBJS)) begin
            wr_cnt = CNT_W'(NUM_OBJS);
        end else begin
            wr_cnt = wr_cnt_raw;
        end
    end

    always_comb begin
        priority if (wr_size_raw < sfla_pkg::SIZE_MIN) begin
            wr_size = sfla_pkg::SIZE_MIN;
        end else if (wr_size_raw > sfla_pkg::SIZE_MAX) begin
            wr_size = sfla_pkg::SIZE_MAX;
        end else begin
            wr_size = wr_size_raw;
        end
    end

    always_comb begin
        unique case (cfg_reg)
            sfla_pkg::REG_COUNT: prdata = sfla_pkg::BUS_W'(r_count);
            sfla_pkg::REG_SIZE:  prdata = sfla_pkg::BUS_W'(r_size);
            sfla_pkg::REG_BASE:  prdata = sfla_pkg::BUS_W'(r_base);
            sfla_pkg::REG_CHECK: prdata = sfla_pkg::BUS_W'(r_check);
            default:             prdata = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_size       = r_size;
        n_base       = r_base;
        n_check      = r_check;
        n_head       = r_head;
        n_free_count = r_free_count;
        n_clr_idx    = r_clr_idx;
        n_m_valid    = r_m_valid && !m_axis_tready;
        n_off        = r_off;
        n_prod       = r_prod;
        n_rem        = r_rem;
        n_dsr        = r_dsr;
        n_q          = r_q;
        n_step       = r_step;
        n_cur        = r_cur;
        n_cur_ok     = r_cur_ok;
        n_left       = r_left;
        n_status     = r_status;
        n_result     = r_result;
        n_m_data     = r_m_data;
        mem_we       = 1'b0;
        mem_waddr    = r_clr_idx;
        mem_wdata    = LW'(r_clr_idx) + LW'(1);
        mem_raddr    = IW'(r_head);

        unique case (r_state)
            sfla_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                n_clr_idx = r_clr_idx + IW'(1);
                if (r_clr_idx == LAST_IDX) begin
                    n_state = sfla_pkg::S_IDLE;
                end
            end
            sfla_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser[0] == sfla_pkg::OP_ALLOC) begin
                        if (r_free_count == '0) begin
                            n_status = sfla_pkg::ST_NO_FREE;
                            n_result = '0;
                            n_state  = sfla_pkg::S_DONE;
                        end else begin
                            n_state = sfla_pkg::S_ALLOC;
                        end
                    end else begin
                        n_off   = KW'(off_aw);
                        n_state = sfla_pkg::S_SPAN;
                    end
                end
            end
            sfla_pkg::S_ALLOC: begin
                // link read of the head and address multiply run together
                n_prod  = mul_p;
                n_state = sfla_pkg::S_ALLOC_WB;
            end
            sfla_pkg::S_ALLOC_WB: begin
                n_head       = head_ok ? r_mem_q : '0;
                n_free_count = r_free_count - CNT_W'(1);
                n_result     = r_base + OW'(r_prod);
                n_status     = sfla_pkg::ST_OK;
                n_state      = sfla_pkg::S_DONE;
            end
            sfla_pkg::S_SPAN: begin
                n_prod  = mul_p;
                n_state = sfla_pkg::S_RANGE;
            end
            sfla_pkg::S_RANGE: begin
                if (r_off >= KW'(r_prod)) begin
                    n_status = sfla_pkg::ST_OUTSIDE;
                    n_result = '0;
                    n_state  = sfla_pkg::S_DONE;
                end else begin
                    // offset < 2 * (size << (CNT_W-1)), so CNT_W quotient bits
                    n_rem   = DIV_W'(r_off);
                    n_dsr   = {r_size, (CNT_W-1)'(0)};
                    n_q     = '0;
                    n_step  = STEP_W'(CNT_W - 1);
                    n_state = sfla_pkg::S_DIV;
                end
            end
            sfla_pkg::S_DIV: begin
                n_rem  = div_ge ? (r_rem - r_dsr) : r_rem;
                n_dsr  = r_dsr >> 1;
                n_q    = {r_q[CNT_W-2:0], div_ge};
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    if (r_check) begin
                        n_cur   = r_head;
                        n_left  = r_free_count;
                        n_state = sfla_pkg::S_WALK_CHK;
                    end else begin
                        n_state = sfla_pkg::S_PUSH;
                    end
                end
            end
            sfla_pkg::S_WALK_CHK: begin
                mem_raddr = IW'(r_cur);
                if (r_left == '0) begin
                    n_state = sfla_pkg::S_PUSH;
                end else if (MW'(r_cur) == MW'(r_q)) begin
                    n_status = sfla_pkg::ST_DOUBLE;
                    n_result = '0;
                    n_state  = sfla_pkg::S_DONE;
                end else begin
                    n_cur_ok = (r_cur < OBJ_LIM);
                    n_left   = r_left - CNT_W'(1);
                    n_state  = sfla_pkg::S_WALK_LD;
                end
            end
            sfla_pkg::S_WALK_LD: begin
                // links past the table read as index zero
                n_cur   = r_cur_ok ? r_mem_q : '0;
                n_state = sfla_pkg::S_WALK_CHK;
            end
            sfla_pkg::S_PUSH: begin
                n_result = '0;
                n_state  = sfla_pkg::S_DONE;
                if (r_free_count >= r_count) begin
                    n_status = sfla_pkg::ST_ALL_FREE;
                end else begin
                    mem_we       = 1'b1;
                    mem_waddr    = IW'(r_q);
                    mem_wdata    = r_head;
                    n_head       = LW'(r_q);
                    n_free_count = r_free_count + CNT_W'(1);
                    n_status     = sfla_pkg::ST_OK;
                end
            end
            sfla_pkg::S_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {F_PAD'(0),
                                 (r_free_count == r_count),
                                 (r_free_count == '0),
                                 r_free_count,
                                 sfla_pkg::FIELD_ADDR_W'(r_result),
                                 r_status};
                    n_state   = sfla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sfla_pkg::S_IDLE;
            end
        endcase

        if (cfg_wr) begin
            unique case (cfg_reg)
                sfla_pkg::REG_COUNT: begin
                    n_count      = wr_cnt;
                    n_head       = '0;
                    n_free_count = wr_cnt;
                    n_clr_idx    = '0;
                    n_state      = sfla_pkg::S_CLEAR;
                end
                sfla_pkg::REG_SIZE:  n_size  = wr_size;
                sfla_pkg::REG_BASE:  n_base  = OW'(pwdata);
                sfla_pkg::REG_CHECK: n_check = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sfla_pkg::S_CLEAR;
            r_count      <= COUNT_RST;
            r_size       <= sfla_pkg::SIZE_RESET;
            r_base       <= '0;
            r_check      <= 1'b1;
            r_head       <= '0;
            r_free_count <= COUNT_RST;
            r_clr_idx    <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_size       <= n_size;
            r_base       <= n_base;
            r_check      <= n_check;
            r_head       <= n_head;
            r_free_count <= n_free_count;
            r_clr_idx    <= n_clr_idx;
            r_m_valid    <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off    <= n_off;
        r_prod   <= n_prod;
        r_rem    <= n_rem;
        r_dsr    <= n_dsr;
        r_q      <= n_q;
        r_step   <= n_step;
        r_cur    <= n_cur;
        r_cur_ok <= n_cur_ok;
        r_left   <= n_left;
        r_status <= n_status;
        r_result <= n_result;
        r_m_data <= n_m_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_raddr];
    end

`ifndef SYNTHESIS
    a_free_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= r_count)
        else $error("free count above object count");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfla_pkg::S_DIV) |-> ({1'b0, r_rem} < {r_dsr, 1'b0}))
        else $error("divider remainder out of bound");

    a_push_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfla_pkg::S_PUSH && r_free_count < r_count && !cfg_wr)
        |=> (r_free_count == $past(r_free_count) + CNT_W'(1)))
        else $error("push did not grow the free list");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_data[F_FULL] == (r_m_data[F_FULL-1:F_FREE] == '0)))
        else $error("slab_full disagrees with free_objects");
`endif

endmodule
